// ----- hdl/cges_pkg.sv -----
// Shared types and constants of the cross-gradient edge suppressor.
// No dependencies; compiled first.
package cges_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int ROW_LIMIT     = 4096;

	localparam int NUM_TAPS = 5;
	localparam int TAP_C    = 0;
	localparam int TAP_U    = 1;
	localparam int TAP_L    = 2;
	localparam int TAP_R    = 3;
	localparam int TAP_D    = 4;

	localparam logic [7:0]  PIX_MAX       = 8'd255;
	localparam logic [9:0]  RST_THRESHOLD = 10'd20;
	localparam logic        RST_INVERT    = 1'b1;
	localparam logic [10:0] RST_WIDTH     = 11'd640;
	localparam logic [12:0] RST_HEIGHT    = 13'd480;

	typedef logic [7:0]  pix_t;
	typedef logic [12:0] cfg_data_t;

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_e;

	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_INVERT    = 2'd1,
		CFG_WIDTH     = 2'd2,
		CFG_HEIGHT    = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [9:0]  edge_threshold;
		logic        invert_enable;
		logic [10:0] frame_width;
		logic [12:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		logic                use_sad;
		logic                last;
		logic [NUM_TAPS-1:0] fwd;
		pix_t                wdata;
	} stage_t;

endpackage

// ----- hdl/cges_ifs.sv -----
// Channel interfaces: pixel input, filtered output and register write.
// Depends on cges_pkg.
interface cges_in_if;
	import cges_pkg::*;
	logic    valid;
	logic    ready;
	opcode_e opcode;
	pix_t    pixel_in;
	modport source (output valid, opcode, pixel_in, input ready);
	modport sink (input valid, opcode, pixel_in, output ready);
endinterface

interface cges_out_if;
	import cges_pkg::*;
	logic valid;
	logic ready;
	pix_t pixel_out;
	logic frame_last;
	modport source (output valid, pixel_out, frame_last, input ready);
	modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

interface cges_cfg_if;
	import cges_pkg::*;
	logic      valid;
	logic      ready;
	cfg_reg_e  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/cges_ram.sv -----
// Generic single-write, single-read RAM with registered, enabled read.
// Read during write to the same address returns the old data. No dependencies.
module cges_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 2050,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/cges_cfg.sv -----
// Configuration register file: threshold, inversion and frame size.
// Depends on cges_pkg.
module cges_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  cges_pkg::cfg_reg_e  wr_index,
	input  cges_pkg::cfg_data_t wr_data,
	output cges_pkg::cfg_t  cfg
);
	import cges_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_threshold <= RST_THRESHOLD;
			cfg_q.invert_enable  <= RST_INVERT;
			cfg_q.frame_width    <= RST_WIDTH;
			cfg_q.frame_height   <= RST_HEIGHT;
		end else if (wr_valid) begin
			unique case (wr_index)
				CFG_THRESHOLD: cfg_q.edge_threshold <= wr_data[9:0];
				CFG_INVERT:    cfg_q.invert_enable  <= wr_data[0];
				CFG_WIDTH:     cfg_q.frame_width    <= wr_data[10:0];
				CFG_HEIGHT:    cfg_q.frame_height   <= wr_data[12:0];
			endcase
		end
	end

endmodule

// ----- hdl/cges_ctrl.sv -----
// Input stage: history pointers, output raster position, tap addresses.
// Issues history writes and reads; depends on cges_pkg.
module cges_ctrl #(
	parameter  int MAX_WIDTH  = cges_pkg::DEF_MAX_WIDTH,
	localparam int HIST_DEPTH = 2 * MAX_WIDTH + 2,
	localparam int AW         = $clog2(HIST_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cges_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cges_pkg::opcode_e    in_opcode,
	input  cges_pkg::pix_t       in_pixel,
	input  logic                 s1_take,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output cges_pkg::pix_t       wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr [cges_pkg::NUM_TAPS],
	output cges_pkg::stage_t     s1
);
	import cges_pkg::*;

	localparam int PW = $clog2(HIST_DEPTH + 1);
	localparam int KW = PW + 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(ROW_LIMIT);
	localparam int HW = RW + 1;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
		logic [AW:0] r;
		r = (v >= (AW+1)'(HIST_DEPTH)) ? v - (AW+1)'(HIST_DEPTH) : v;
		return r[AW-1:0];
	endfunction

	logic [AW-1:0] wr_q;
	logic [PW-1:0] pend_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;
	stage_t        s1_q;

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic          is_pix, accept, emit, interior, have_next, last;
	logic          col_wrap, row_wrap;
	logic [AW-1:0] wr_inc, wr_e, ctr;
	logic [PW-1:0] pend_inc, pend_e;
	logic [AW:0]   ctr_sum;

	always_comb begin
		if (cfg.frame_width == '0) begin
			eff_w = WW'(1);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			eff_h = HW'(1);
		end else if (32'(cfg.frame_height) > ROW_LIMIT) begin
			eff_h = HW'(ROW_LIMIT);
		end else begin
			eff_h = HW'(cfg.frame_height);
		end
	end

	assign is_pix   = (in_opcode == OP_PIXEL);
	assign in_ready = !s1_q.valid || s1_take;
	assign accept   = in_valid && in_ready;

	assign wr_inc   = (wr_q == AW'(HIST_DEPTH - 1)) ? '0 : wr_q + AW'(1);
	assign pend_inc = (pend_q == PW'(HIST_DEPTH)) ? pend_q : pend_q + PW'(1);
	assign wr_e     = is_pix ? wr_inc : wr_q;
	assign pend_e   = is_pix ? pend_inc : pend_q;

	assign emit = is_pix ? (KW'(pend_e) > KW'(eff_w) + KW'(1)) : (pend_q != '0);

	assign ctr_sum = (AW+1)'(wr_e) + (AW+1)'(HIST_DEPTH) - (AW+1)'(pend_e);
	assign ctr     = wrap(ctr_sum);

	assign rd_addr[TAP_C] = ctr;
	assign rd_addr[TAP_U] = wrap({1'b0, ctr} + (AW+1)'(HIST_DEPTH) - (AW+1)'(eff_w));
	assign rd_addr[TAP_L] = wrap({1'b0, ctr} + (AW+1)'(HIST_DEPTH - 1));
	assign rd_addr[TAP_R] = wrap({1'b0, ctr} + (AW+1)'(1));
	assign rd_addr[TAP_D] = wrap({1'b0, ctr} + (AW+1)'(eff_w));

	assign interior = (orow_q != '0) && (HW'(orow_q) + HW'(2) <= eff_h) &&
	                  (ocol_q != '0) && ((WW+1)'(ocol_q) + (WW+1)'(2) <= (WW+1)'(eff_w));
	assign have_next = KW'(pend_e) > KW'(eff_w);
	assign last      = (HW'(orow_q) + HW'(1) == eff_h) && (WW'(ocol_q) + WW'(1) == eff_w);
	assign col_wrap  = (WW'(ocol_q) + WW'(1) >= eff_w);
	assign row_wrap  = (HW'(orow_q) + HW'(1) >= eff_h);

	assign wr_en   = accept && is_pix;
	assign wr_addr = wr_q;
	assign wr_data = cfg.invert_enable ? PIX_MAX - in_pixel : in_pixel;
	assign rd_en   = accept && emit;
	assign s1      = s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			pend_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			s1_q   <= '0;
		end else if (accept) begin
			wr_q         <= wr_e;
			pend_q       <= emit ? pend_e - PW'(1) : pend_e;
			s1_q.valid   <= emit;
			s1_q.use_sad <= interior && have_next;
			s1_q.last    <= last;
			s1_q.wdata   <= wr_data;
			for (int k = 0; k < NUM_TAPS; k++) begin
				s1_q.fwd[k] <= is_pix && (rd_addr[k] == wr_q);
			end
			if (emit) begin
				ocol_q <= col_wrap ? '0 : ocol_q + CW'(1);
				if (col_wrap) begin
					orow_q <= row_wrap ? '0 : orow_q + RW'(1);
				end
			end
		end else if (s1_take) begin
			s1_q.valid <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(HIST_DEPTH))
		else $error("pending count beyond history depth");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q < AW'(HIST_DEPTH))
		else $error("write pointer beyond history depth");
	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_pix && pend_q == '0) |=> !s1_q.valid)
		else $error("drain with nothing pending produced a result");
	a_pend_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_pix && pend_q != '0) |=> (pend_q == $past(pend_q) - PW'(1)))
		else $error("drain did not release exactly one pixel");
`endif

endmodule

// ----- hdl/cges_filter.sv -----
// Result stage: neighbor difference sum, threshold compare, output register.
// Depends on cges_pkg.
module cges_filter (
	input  logic             clk,
	input  logic             arst_n,
	input  cges_pkg::stage_t s1,
	input  cges_pkg::pix_t   tap_q [cges_pkg::NUM_TAPS],
	input  logic [9:0]       edge_threshold,
	output logic             s1_take,
	input  logic             out_ready,
	output logic             out_valid,
	output cges_pkg::pix_t   pixel_out,
	output logic             frame_last
);
	import cges_pkg::*;

	function automatic pix_t absdiff(input pix_t a, input pix_t b);
		return (a > b) ? a - b : b - a;
	endfunction

	pix_t       v [NUM_TAPS];
	logic [9:0] sum;
	logic       out_valid_q;
	pix_t       pixel_q;
	logic       last_q;

	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			v[k] = s1.fwd[k] ? s1.wdata : tap_q[k];
		end
	end

	assign sum = 10'(absdiff(v[TAP_C], v[TAP_U])) + 10'(absdiff(v[TAP_C], v[TAP_L])) +
	             10'(absdiff(v[TAP_C], v[TAP_R])) + 10'(absdiff(v[TAP_C], v[TAP_D]));

	assign s1_take    = s1.valid && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_q;
	assign frame_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			pixel_q <= (s1.use_sad && sum > edge_threshold) ? '0 : v[TAP_C];
			last_q  <= s1.last;
		end
	end

endmodule

// ----- hdl/cross_gradient_edge_suppress.sv -----
// Cross-gradient edge suppressor, top level.
// Depends on cges_pkg, cges_ifs, cges_cfg, cges_ctrl, cges_ram, cges_filter.
//
// Usage
//   pixels: one transaction per pixel in raster order (opcode pixel), or a
//     drain transaction that releases one pending pixel at frame end.
//   results: filtered pixels in raster order, one row plus one pixel behind
//     the input; frame_last marks the bottom-right pixel.
//   cfg: register writes, always ready; write only while the block is idle.
// Timing
//   One transaction per cycle on both sides while results is not stalled.
//   A result passes through the registered history reads (five RAM copies,
//   one per tap: center and four neighbors), then through the sum, compare
//   and output register.
// Reset
//   Registers return to their defaults and the pointers clear; the history
//   RAM keeps its contents and needs no clearing pass.
// Stall
//   With results stalled, the read stage and the output register fill and
//   pixels.ready drops; nothing is lost or repeated.
module cross_gradient_edge_suppress #(
	parameter int MAX_WIDTH = cges_pkg::DEF_MAX_WIDTH
) (
	input logic          clk,
	input logic          arst_n,
	cges_in_if.sink      pixels,
	cges_out_if.source   results,
	cges_cfg_if.sink     cfg
);
	import cges_pkg::*;

	localparam int HIST_DEPTH = 2 * MAX_WIDTH + 2;
	localparam int AW         = $clog2(HIST_DEPTH);

	cfg_t          cfg_val;
	stage_t        s1;
	logic          s1_take;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr;
	pix_t          wr_data;
	logic [AW-1:0] rd_addr [NUM_TAPS];
	pix_t          tap_q [NUM_TAPS];

	cges_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	cges_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_val),
		.in_valid  (pixels.valid),
		.in_ready  (pixels.ready),
		.in_opcode (pixels.opcode),
		.in_pixel  (pixels.pixel_in),
		.s1_take   (s1_take),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.s1        (s1)
	);

	for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
		cges_ram #(.WIDTH($bits(pix_t)), .DEPTH(HIST_DEPTH)) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (wr_addr),
			.wdata (wr_data),
			.re    (rd_en),
			.raddr (rd_addr[g]),
			.rdata (tap_q[g])
		);
	end

	cges_filter u_filter (
		.clk            (clk),
		.arst_n         (arst_n),
		.s1             (s1),
		.tap_q          (tap_q),
		.edge_threshold (cfg_val.edge_threshold),
		.s1_take        (s1_take),
		.out_ready      (results.ready),
		.out_valid      (results.valid),
		.pixel_out      (results.pixel_out),
		.frame_last     (results.frame_last)
	);

endmodule
